[hw/rtl/uttb_pkg.sv]
// Shared types, constants and decode functions for the UUID text-to-binary unit.
package uttb_pkg;

  localparam int TEXT_LENGTH = 36;
  localparam int BYTE_COUNT  = 16;
  localparam int POS_W       = 6;
  localparam int NIB_W       = 5;
  localparam int IDX_W       = $clog2(BYTE_COUNT);
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [POS_W-1:0] POS_SAT  = POS_W'(TEXT_LENGTH + 1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(TEXT_LENGTH - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BYTE_COUNT - 1);

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_NULL = 1'b1;

  localparam logic REG_SWAP_MODE = 1'b0;

  typedef logic [7:0] byte_t;
  typedef byte_t [BYTE_COUNT-1:0] byte_vec_t;

  typedef struct packed {
    logic             hit;
    logic [NIB_W-1:0] idx;
  } nib_map_t;

  typedef struct packed {
    logic      valid;
    logic      good;
    byte_vec_t bytes;
  } emit_req_t;

  // 0..15 for a hex digit, 16 otherwise
  function automatic logic [4:0] digit_value(input logic [7:0] ch);
    logic [7:0] lc;
    lc = ch | 8'h20;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      return {1'b0, ch[3:0]};
    end else if (lc >= 8'h61 && lc <= 8'h66) begin
      return {1'b0, lc[3:0] + 4'd9};
    end else begin
      return 5'd16;
    end
  endfunction

  // text position to nibble index; hyphen slots and overflow do not hit
  function automatic nib_map_t nib_map(input logic [POS_W-1:0] pos);
    nib_map_t m;
    m.hit = 1'b1;
    m.idx = '0;
    if (pos >= POS_W'(TEXT_LENGTH) || pos == POS_W'(8) || pos == POS_W'(13) ||
        pos == POS_W'(18) || pos == POS_W'(23)) begin
      m.hit = 1'b0;
    end else if (pos < POS_W'(8)) begin
      m.idx = pos[NIB_W-1:0];
    end else if (pos < POS_W'(13)) begin
      m.idx = NIB_W'(pos - POS_W'(1));
    end else if (pos < POS_W'(18)) begin
      m.idx = NIB_W'(pos - POS_W'(2));
    end else if (pos < POS_W'(23)) begin
      m.idx = NIB_W'(pos - POS_W'(3));
    end else begin
      m.idx = NIB_W'(pos - POS_W'(4));
    end
    return m;
  endfunction

  // source byte for output slot k in time-swapped order
  function automatic logic [IDX_W-1:0] swap_src(input int k);
    case (k)
      0:       return IDX_W'(6);
      1:       return IDX_W'(7);
      2:       return IDX_W'(4);
      3:       return IDX_W'(5);
      4:       return IDX_W'(0);
      5:       return IDX_W'(1);
      6:       return IDX_W'(2);
      7:       return IDX_W'(3);
      default: return IDX_W'(k);
    endcase
  endfunction

endpackage

[hw/rtl/uttb_parser.sv]
// Character parser: position tracking, hex decode and byte store.
module uttb_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          text_char,
  input  logic                char_last,
  output uttb_pkg::emit_req_t req
);
  import uttb_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [3:0]       hi_r, hi_nxt;
  logic             bad_r, bad_nxt;
  byte_vec_t        store_r;
  byte_vec_t        merged;
  nib_map_t         nm;
  logic [4:0]       dv;
  logic             dbad;
  logic [3:0]       val;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;

  always_comb begin
    nm     = nib_map(pos_r);
    dv     = digit_value(text_char);
    dbad   = nm.hit & dv[4];
    val    = dv[4] ? 4'd0 : dv[3:0];
    wr_en  = nm.hit & nm.idx[0];
    wr_idx = nm.idx[NIB_W-1:1];

    pos_nxt = (pos_r < POS_SAT) ? pos_r + POS_W'(1) : pos_r;
    hi_nxt  = (nm.hit && !nm.idx[0]) ? val : hi_r;
    bad_nxt = bad_r | dbad;
    if (char_last) begin
      pos_nxt = '0;
      hi_nxt  = '0;
      bad_nxt = 1'b0;
    end

    merged = store_r;
    if (wr_en) begin
      merged[wr_idx] = {hi_r, val};
    end

    req.valid = acc & char_last;
    req.good  = (pos_r == POS_LAST) & ~bad_r & ~dbad;
    req.bytes = merged;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      hi_r  <= '0;
      bad_r <= 1'b0;
    end else if (acc) begin
      pos_r <= pos_nxt;
      hi_r  <= hi_nxt;
      bad_r <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && wr_en) begin
      store_r[wr_idx] <= {hi_r, val};
    end
  end

endmodule

[hw/rtl/uttb_emitter.sv]
// Result buffer: loads a finished UUID and shifts out one byte per word.
module uttb_emitter (
  input  logic                clk,
  input  logic                rst_n,
  input  uttb_pkg::emit_req_t req,
  input  logic                swap_mode,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic                out_status
);
  import uttb_pkg::*;

  logic             valid_r;
  logic             null_r;
  logic [IDX_W-1:0] cnt_r;
  byte_vec_t        buf_r;
  byte_vec_t        ordered;
  logic             take;

  always_comb begin
    for (int k = 0; k < BYTE_COUNT; k++) begin
      ordered[k] = swap_mode ? req.bytes[swap_src(k)] : req.bytes[k];
    end
  end

  assign take       = valid_r & out_ready;
  assign busy       = valid_r;
  assign out_valid  = valid_r;
  assign out_byte   = buf_r[0];
  assign out_last   = null_r | (cnt_r == IDX_LAST);
  assign out_status = null_r ? STATUS_NULL : STATUS_OK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      null_r  <= 1'b0;
      cnt_r   <= '0;
    end else if (req.valid) begin
      valid_r <= 1'b1;
      null_r  <= ~req.good;
      cnt_r   <= '0;
    end else if (take) begin
      if (out_last) begin
        valid_r <= 1'b0;
      end
      cnt_r <= cnt_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      if (req.good) begin
        buf_r <= ordered;
      end else begin
        buf_r[0] <= '0;
      end
    end else if (take) begin
      for (int k = 0; k < BYTE_COUNT - 1; k++) begin
        buf_r[k] <= buf_r[k+1];
      end
    end
  end

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |-> !valid_r)
    else $error("load while result pending");

  a_null_single: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && null_r) |-> (out_last && cnt_r == '0))
    else $error("null status not a single last word");

  a_drop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (take && out_last) |=> !valid_r)
    else $error("valid held after last word");

  a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !out_last) |=> (valid_r && cnt_r == $past(cnt_r) + IDX_W'(1)))
    else $error("byte count did not advance");

endmodule

[hw/rtl/uuid_text_to_binary_unit.sv]
// Top level of the UUID text-to-binary unit with its configuration register.
// Latency: a final character is accepted, its first result word is valid the next cycle.
// Throughput: one character per cycle; 16 words per good UUID, one per out_ready cycle.
// A final character is held off while the previous result is still being emitted.
// Reset (synchronous, rst_n low) clears position, digit state, output flags and swap_mode.
module uuid_text_to_binary_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_text_char,
  input  logic                        in_char_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_byte,
  output logic                        out_last,
  output logic                        out_status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [uttb_pkg::ADDR_W-1:0] paddr,
  input  logic [uttb_pkg::DATA_W-1:0] pwdata,
  output logic [uttb_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import uttb_pkg::*;

  logic      swap_r;
  logic      busy;
  logic      acc;
  logic      reg_sel;
  emit_req_t req;

  assign in_ready = ~in_char_last | ~busy;
  assign acc      = in_valid & in_ready;
  assign pready   = 1'b1;
  assign reg_sel  = (paddr[2] == REG_SWAP_MODE);
  assign prdata   = reg_sel ? {{(DATA_W-1){1'b0}}, swap_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      swap_r <= pwdata[0];
    end
  end

  uttb_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .text_char (in_text_char),
    .char_last (in_char_last),
    .req       (req)
  );

  uttb_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .swap_mode  (swap_r),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .out_status (out_status)
  );

endmodule

[bench/uttb_checker.sv]
// Checker for the UUID text-to-binary unit: predicts result words and compares them.
module uttb_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [7:0]                  in_text_char,
  input  logic                        in_char_last,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [7:0]                  out_byte,
  input  logic                        out_last,
  input  logic                        out_status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [uttb_pkg::ADDR_W-1:0] paddr,
  input  logic [uttb_pkg::DATA_W-1:0] pwdata,
  input  logic                        pready,
  output int                          fail_count,
  output int                          expected_left
);

  localparam logic [uttb_pkg::ADDR_W-1:0] SWAP_ADDR =
    uttb_pkg::ADDR_W'(4 * uttb_pkg::REG_SWAP_MODE);
  localparam int DASH_POS [4] = '{8, 13, 18, 23};
  localparam int TIME_SWAP [uttb_pkg::BYTE_COUNT] =
    '{6, 7, 4, 5, 0, 1, 2, 3, 8, 9, 10, 11, 12, 13, 14, 15};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       status;
  } uuid_word_t;

  uuid_word_t word_q [$];
  logic       swap_on;
  int         text_pos;
  logic [3:0] upper_nib;
  logic       bad_digit;
  logic [7:0] byte_mem [uttb_pkg::BYTE_COUNT];
  int         fails = 0;

  // 0..15 for a hex digit in either case, 16 for anything else
  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [7:0] folded;
    folded = ch | 8'h20;
    if (ch >= 8'h30 && ch <= 8'h39) return 5'(ch - 8'h30);
    if (folded >= 8'h61 && folded <= 8'h66) return 5'(folded - 8'h57);
    return 5'd16;
  endfunction

  // nibble index of a text position, -1 on dash slots and past the end
  function automatic int nibble_slot(input int pos);
    int slot;
    slot = pos;
    if (pos >= uttb_pkg::TEXT_LENGTH) return -1;
    foreach (DASH_POS[i]) begin
      if (pos == DASH_POS[i]) return -1;
      if (pos > DASH_POS[i]) slot--;
    end
    return slot;
  endfunction

  function automatic void decode_char(input logic [7:0] ch, input logic last);
    int         slot;
    int         src;
    logic [4:0] v;
    slot = nibble_slot(text_pos);
    if (slot >= 0) begin
      v = hex_value(ch);
      if (v[4]) begin
        bad_digit = 1'b1;
        v = '0;
      end
      if (slot % 2 == 0) begin
        upper_nib = v[3:0];
      end else begin
        byte_mem[slot / 2] = {upper_nib, v[3:0]};
      end
    end
    if (text_pos <= uttb_pkg::TEXT_LENGTH) text_pos++;
    if (!last) return;
    if (text_pos != uttb_pkg::TEXT_LENGTH || bad_digit) begin
      word_q.push_back('{data: 8'h00, last: 1'b1, status: uttb_pkg::STATUS_NULL});
    end else begin
      for (int k = 0; k < uttb_pkg::BYTE_COUNT; k++) begin
        src = swap_on ? TIME_SWAP[k] : k;
        word_q.push_back('{data: byte_mem[src], last: k == uttb_pkg::BYTE_COUNT - 1,
                           status: uttb_pkg::STATUS_OK});
      end
    end
    text_pos  = 0;
    upper_nib = '0;
    bad_digit = 1'b0;
  endfunction

  always @(posedge clk) begin
    uuid_word_t head;
    if (!rst_n) begin
      swap_on   = 1'b0;
      text_pos  = 0;
      upper_nib = '0;
      bad_digit = 1'b0;
      word_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (word_q.size() == 0) begin
          $display("%0t: unexpected word byte=%h last=%b status=%b",
                   $time, out_byte, out_last, out_status);
          fails++;
        end else begin
          head = word_q.pop_front();
          if (out_byte !== head.data) begin
            $display("%0t: byte expected %h actual %h", $time, head.data, out_byte);
            fails++;
          end
          if (out_last !== head.last) begin
            $display("%0t: last expected %b actual %b", $time, head.last, out_last);
            fails++;
          end
          if (out_status !== head.status) begin
            $display("%0t: status expected %b actual %b", $time, head.status, out_status);
            fails++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == SWAP_ADDR) swap_on = pwdata[0];
      if (in_valid && in_ready) decode_char(in_text_char, in_char_last);
    end
    fail_count    <= fails;
    expected_left <= word_q.size();
  end

endmodule

[bench/tb_top.sv]
// Testbench top for the UUID text-to-binary unit: clock, reset, stimulus and verdict.
module tb_top;

  localparam logic [uttb_pkg::ADDR_W-1:0] SWAP_ADDR =
    uttb_pkg::ADDR_W'(4 * uttb_pkg::REG_SWAP_MODE);
  localparam logic [uttb_pkg::ADDR_W-1:0] SPARE_ADDR =
    uttb_pkg::ADDR_W'(4 * (uttb_pkg::REG_SWAP_MODE + 1));
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_ITEMS  = 25;
  localparam logic [7:0] NOT_HEX [10] =
    '{8'h00, 8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, 8'hC1, 8'hE6, 8'hFF};
  localparam bit SWAP_PLAN [4] = '{1'b1, 1'b1, 1'b0, 1'b1};

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  bit                          clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [7:0]                  in_text_char;
  logic                        in_char_last;
  logic                        out_valid;
  logic                        out_ready;
  logic [7:0]                  out_byte;
  logic                        out_last;
  logic                        out_status;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [uttb_pkg::ADDR_W-1:0] paddr;
  logic [uttb_pkg::DATA_W-1:0] pwdata;
  logic [uttb_pkg::DATA_W-1:0] prdata;
  logic                        pready;
  int                          fail_count;
  int                          expected_left;

  bit hold_req   = 1'b0;
  bit steady     = 1'b0;
  int burst_left = 0;
  int items_sent = 0;

  always #1 clk = ~clk;

  uuid_text_to_binary_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_text_char (in_text_char),
    .in_char_last (in_char_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_status   (out_status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  uttb_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_text_char  (in_text_char),
    .in_char_last  (in_char_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .out_status    (out_status),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  function automatic bit dash_slot(input int p);
    return p == 8 || p == 13 || p == 18 || p == 23;
  endfunction

  function automatic logic [7:0] hex_char(input int v, input bit upper);
    if (v < 10) return 8'(8'h30 + v);
    return 8'((upper ? 8'h41 : 8'h61) + v - 10);
  endfunction

  // one word on the input channel, bursts with random gaps in between
  task automatic put_char(input logic [7:0] ch, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_text_char <= ch;
    in_char_last <= last;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input int len, input bit bad);
    int         bad_pos;
    logic [7:0] ch;
    bad_pos = -1;
    if (bad) begin
      do bad_pos = $urandom_range(0, uttb_pkg::TEXT_LENGTH - 1); while (dash_slot(bad_pos));
    end
    for (int p = 0; p < len; p++) begin
      if (dash_slot(p)) begin
        ch = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'h2D;
      end else if (p == bad_pos) begin
        ch = NOT_HEX[$urandom_range(0, 9)];
      end else begin
        ch = hex_char($urandom_range(0, 15), $urandom_range(0, 1));
      end
      put_char(ch, p == len - 1);
    end
  endtask

  task automatic send_noise();
    int         len;
    logic [7:0] ch;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(37, 63) : $urandom_range(1, 40);
    for (int p = 0; p < len; p++) begin
      if ($urandom_range(0, 3) == 0) begin
        ch = hex_char($urandom_range(0, 15), $urandom_range(0, 1));
      end else begin
        ch = 8'($urandom_range(0, 255));
      end
      put_char(ch, p == len - 1);
    end
  endtask

  task automatic send_random_string();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      send_text(uttb_pkg::TEXT_LENGTH, 1'b0);
    end else if (pick == 6) begin
      send_text(uttb_pkg::TEXT_LENGTH, 1'b1);
    end else if (pick == 7) begin
      send_text($urandom_range(0, 1) ? uttb_pkg::TEXT_LENGTH - 1 : $urandom_range(37, 44),
                1'b0);
    end else begin
      send_noise();
    end
  endtask

  task automatic write_reg(input logic [uttb_pkg::ADDR_W-1:0] addr, input bit val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= ($urandom() & 32'hFFFF_FFFE) | 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // sender goes quiet until every expected word has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : receiver
    rx_mode_t mode;
    int       seg_left;
    int       tick;
    mode      = RX_OPEN;
    seg_left  = 0;
    tick      = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (seg_left == 0) begin
        mode     = rx_mode_t'($urandom_range(0, 3));
        seg_left = $urandom_range(8, 60);
      end
      seg_left--;
      tick++;
      case (mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= (tick % 3 != 0);
      endcase
    end
  end

  initial begin : stimulus
    string text;
    int    phase_start;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_text_char = '0;
    in_char_last = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lone final character, then a full string with junk in two of the dash slots
    put_char(8'h41, 1'b1);
    text = "00000000-FFFF-ffff-aF09-9a0f00ffFFaa";
    text[13] = 8'hFF;
    text[18] = 8'h7A;
    for (int i = 0; i < uttb_pkg::TEXT_LENGTH; i++) begin
      put_char(text[i], i == uttb_pkg::TEXT_LENGTH - 1);
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_reg(SWAP_ADDR, SWAP_PLAN[ph]);
      if (ph == 1) write_reg(SPARE_ADDR, ~SWAP_PLAN[ph]);
      if (ph == 2) begin
        hold_req = 1'b1;
        steady   = 1'b1;
        repeat (2) send_text(uttb_pkg::TEXT_LENGTH, 1'b0);
        steady   = 1'b0;
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_random_string();
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[files.f]
hw/rtl/uttb_pkg.sv
hw/rtl/uttb_parser.sv
hw/rtl/uttb_emitter.sv
hw/rtl/uuid_text_to_binary_unit.sv
bench/uttb_checker.sv
bench/tb_top.sv
